// ===== rtl/core/acfd_pkg.sv =====
// Package for the ASCII CAN frame deframer: sizes, character codes and the
// structs passed between the parser and the readout sequencer.
// No dependencies.
`default_nettype none

package acfd_pkg;

  localparam int MAX_VALUE_CHARS = 16;
  localparam int IDX_W = (MAX_VALUE_CHARS > 1) ? $clog2(MAX_VALUE_CHARS) : 1;
  localparam int CNT_W = $clog2(MAX_VALUE_CHARS + 1);

  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_S    = 8'h73;  // 's'
  localparam logic [7:0] CH_D    = 8'h64;  // 'd'
  localparam logic [7:0] CH_0    = 8'h30;  // '0'
  localparam logic [7:0] CH_1    = 8'h31;  // '1'
  localparam logic [7:0] CH_4    = 8'h34;  // '4'
  localparam logic [7:0] CH_5    = 8'h35;  // '5'
  localparam logic [7:0] CH_9    = 8'h39;  // '9'
  localparam logic [7:0] CH_DOT  = 8'h2e;  // '.'

  // Write into the value buffer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } acfd_wr_t;

  // Handoff of a completed frame to the readout sequencer.
  typedef struct packed {
    logic             start;
    logic [7:0]       id;
    logic [7:0]       status;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } acfd_frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/acfd_in_if.sv =====
// Input byte channel of the ASCII CAN frame deframer.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface acfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acfd_out_if.sv =====
// Result channel of the ASCII CAN frame deframer, one value character a beat.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface acfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] can_id;
  logic [7:0] status_char;
  logic [7:0] value_char;
  logic [3:0] char_index;
  logic [4:0] value_length;
  logic       truncated;
  logic       last;

  modport source (output valid, output can_id, output status_char,
                  output value_char, output char_index, output value_length,
                  output truncated, output last, input ready);
  modport sink   (input valid, input can_id, input status_char,
                  input value_char, input char_index, input value_length,
                  input truncated, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acfd_parser.sv =====
// Byte-level frame parser: tracks the fixed frame head, captures ID and
// status, and writes value characters into the readout buffer. Uses acfd_pkg.
`default_nettype none

module acfd_parser import acfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  byte_in,
  input  logic        busy,
  output logic        byte_ready,
  output acfd_wr_t    wr,
  output acfd_frame_t frame
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_ID     = 6'b000010,
    PH_SEP_S  = 6'b000100,
    PH_STATUS = 6'b001000,
    PH_SEP_D  = 6'b010000,
    PH_VALUE  = 6'b100000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             take;

  assign byte_ready = !busy;
  assign take       = byte_valid && byte_ready;

  always_comb begin
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    status_nxt   = status_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    wr           = '0;
    frame.start  = 1'b0;
    frame.id     = id_r;
    frame.status = status_r;
    frame.count  = count_r;
    frame.ovf    = ovf_r;
    if (take) begin
      case (phase_r)
        PH_IDLE: begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          phase_nxt = (byte_in == CH_BANG) ? PH_ID : PH_IDLE;
        end
        PH_ID: begin
          id_nxt    = byte_in;
          phase_nxt = PH_SEP_S;
        end
        PH_SEP_S: begin
          phase_nxt = (byte_in == CH_S) ? PH_STATUS : PH_IDLE;
        end
        PH_STATUS: begin
          if (byte_in inside {CH_0, CH_1, CH_4, CH_5}) begin
            status_nxt = byte_in;
            phase_nxt  = PH_SEP_D;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_SEP_D: begin
          phase_nxt = (byte_in == CH_D) ? PH_VALUE : PH_IDLE;
        end
        PH_VALUE: begin
          if ((byte_in inside {[CH_0:CH_9]}) || (byte_in == CH_DOT)) begin
            if (count_r < CNT_W'(MAX_VALUE_CHARS)) begin
              wr.we     = 1'b1;
              wr.addr   = count_r[IDX_W-1:0];
              wr.data   = byte_in;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            // The closing byte is consumed; an empty run just drops the frame.
            frame.start = (count_r != '0);
            count_nxt   = '0;
            ovf_nxt     = 1'b0;
            phase_nxt   = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      id_r     <= '0;
      status_r <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      id_r     <= id_nxt;
      status_r <= status_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/acfd_readout.sv =====
// Value buffer and readout sequencer: one index counter walks the buffer
// and drives one result beat per stored character. Uses acfd_pkg.
`default_nettype none

module acfd_readout import acfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  acfd_wr_t    wr,
  input  acfd_frame_t frame,
  output logic        busy,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  res_id,
  output logic [7:0]  res_status,
  output logic [7:0]  res_value,
  output logic [3:0]  res_index,
  output logic [4:0]  res_length,
  output logic        res_trunc,
  output logic        res_last
);

  typedef enum logic [2:0] {
    RD_IDLE  = 3'b001,
    RD_FETCH = 3'b010,
    RD_SHOW  = 3'b100
  } rd_state_t;

  logic [7:0]       store [MAX_VALUE_CHARS];
  rd_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       status_r, status_nxt;
  logic             trunc_r, trunc_nxt;
  logic             last_r, last_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       value_r;
  logic             at_end;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      store[wr.addr] <= wr.data;
    end
  end

  // Registered buffer read lands directly in the result register.
  always_ff @(posedge clk) begin
    if (state_r == RD_FETCH) begin
      value_r <= store[idx_r];
    end
  end

  assign at_end = ((CNT_W'(idx_r) + CNT_W'(1)) == len_r);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    id_nxt     = id_r;
    status_nxt = status_r;
    trunc_nxt  = trunc_r;
    last_nxt   = last_r;
    valid_nxt  = valid_r;
    case (state_r)
      RD_IDLE: begin
        if (frame.start) begin
          idx_nxt    = '0;
          len_nxt    = frame.count;
          id_nxt     = frame.id;
          status_nxt = frame.status;
          trunc_nxt  = frame.ovf;
          state_nxt  = RD_FETCH;
        end
      end
      RD_FETCH: begin
        last_nxt  = at_end;
        valid_nxt = 1'b1;
        state_nxt = RD_SHOW;
      end
      RD_SHOW: begin
        if (res_ready) begin
          valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = RD_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = RD_FETCH;
          end
        end
      end
      default: begin
        valid_nxt = 1'b0;
        state_nxt = RD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RD_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    len_r    <= len_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
    trunc_r  <= trunc_nxt;
    last_r   <= last_nxt;
  end

  assign busy       = (state_r != RD_IDLE);
  assign res_valid  = valid_r;
  assign res_id     = id_r;
  assign res_status = status_r;
  assign res_value  = value_r;
  assign res_index  = 4'(idx_r);
  assign res_length = 5'(len_r);
  assign res_trunc  = trunc_r;
  assign res_last   = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/ascii_can_frame_deframer_core.sv =====
// Top level of the ASCII CAN frame deframer: parser plus readout sequencer.
// Uses acfd_pkg, acfd_in_if, acfd_out_if, acfd_parser and acfd_readout.
//
// Input bytes are taken one per cycle while a frame is being parsed. The byte
// that closes a non-empty value run starts a readout burst; during the burst
// the input is not ready, and the sequencer walks the value buffer with one
// index counter, taking each stored character through a buffer read and then
// the result beat, which may wait on out_ch.ready; input is held off until the
// frame's last beat is taken. The buffer holds 16 characters; no clearing pass
// is needed after reset.
`default_nettype none

module ascii_can_frame_deframer_core import acfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  acfd_in_if.sink    in_ch,
  acfd_out_if.source out_ch
);

  acfd_wr_t    wr;
  acfd_frame_t frame;
  logic        busy;

  acfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_in    (in_ch.in_byte),
    .busy       (busy),
    .byte_ready (in_ch.ready),
    .wr         (wr),
    .frame      (frame)
  );

  acfd_readout u_readout (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .frame      (frame),
    .busy       (busy),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_id     (out_ch.can_id),
    .res_status (out_ch.status_char),
    .res_value  (out_ch.value_char),
    .res_index  (out_ch.char_index),
    .res_length (out_ch.value_length),
    .res_trunc  (out_ch.truncated),
    .res_last   (out_ch.last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/acfd_checker.sv =====
// Port-level checks for the ASCII CAN frame deframer, bound to the top level.
// Depends on ascii_can_frame_deframer_core and its channel interfaces.
`default_nettype none

module acfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value_char,
  input logic [3:0] out_char_index,
  input logic [4:0] out_value_length,
  input logic       out_last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_char)
      && $stable(out_char_index) && $stable(out_last))
    else $error("result beat changed while stalled");

  // Input stays blocked while a result is on offer.
  a_no_input_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during readout burst");

  // A taken beat that is not the last keeps the input blocked.
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input ready before the frame's last beat");

  // The last beat sits at the end of the stored run.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (5'(out_char_index) + 5'd1) == out_value_length)
    else $error("last beat index does not match frame length");

  // Index stays inside the frame.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 5'(out_char_index) < out_value_length)
    else $error("char index outside frame length");

endmodule

bind ascii_can_frame_deframer_core acfd_checker u_acfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_value_char   (out_ch.value_char),
  .out_char_index   (out_ch.char_index),
  .out_value_length (out_ch.value_length),
  .out_last         (out_ch.last)
);

`default_nettype wire

// ===== verif/tb_ascii_can_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ascii_can_frame_deframer_core: feeds text bytes, predicts
// the per-character result beats and checks them in order. Needs acfd_pkg, acfd_in_if,
// acfd_out_if and the core itself.

module tb_ascii_can_frame_deframer_core import acfd_pkg::*; ();

  localparam logic [7:0] CH_E = 8'h65;  // 'e'

  typedef enum logic [2:0] {HUNT, TAKE_ID, WANT_S, TAKE_STATUS, WANT_D, IN_VALUE} phase_t;

  typedef struct packed {
    logic [7:0] can_id;
    logic [7:0] status_char;
    logic [7:0] value_char;
    logic [3:0] char_index;
    logic [4:0] value_length;
    logic       truncated;
    logic       last;
  } frame_char_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        typed;
    frame_char_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  acfd_in_if  in_ch ();
  acfd_out_if out_ch ();

  ascii_can_frame_deframer_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  phase_t      dp_phase;
  logic [7:0]  dp_id;
  logic [7:0]  dp_status;
  logic [7:0]  dp_buf [MAX_VALUE_CHARS];
  int          dp_count;
  logic        dp_ovf;

  frame_char_t fresh_chars [$];
  frame_char_t pending_chars [$];
  stim_row_t   offered_rows [$];
  int          mismatches;
  bit          hold_req;
  bit          hold_done;

  function automatic void deframe_byte(input logic [7:0] b);
    frame_char_t fc;
    case (dp_phase)
      HUNT: begin
        dp_count = 0;
        dp_ovf   = 1'b0;
        dp_phase = (b == CH_BANG) ? TAKE_ID : HUNT;
      end
      TAKE_ID: begin
        dp_id    = b;
        dp_phase = WANT_S;
      end
      WANT_S: dp_phase = (b == CH_S) ? TAKE_STATUS : HUNT;
      TAKE_STATUS: begin
        if (b == CH_0 || b == CH_1 || b == CH_4 || b == CH_5) begin
          dp_status = b;
          dp_phase  = WANT_D;
        end else begin
          dp_phase = HUNT;
        end
      end
      WANT_D: dp_phase = (b == CH_D) ? IN_VALUE : HUNT;
      IN_VALUE: begin
        if ((b >= CH_0 && b <= CH_9) || b == CH_DOT) begin
          if (dp_count < MAX_VALUE_CHARS) begin
            dp_buf[dp_count] = b;
            dp_count++;
          end else begin
            dp_ovf = 1'b1;
          end
        end else begin
          // The closing byte is swallowed; an empty run gives nothing.
          for (int k = 0; k < dp_count; k++) begin
            fc.can_id       = dp_id;
            fc.status_char  = dp_status;
            fc.value_char   = dp_buf[k];
            fc.char_index   = k[3:0];
            fc.value_length = dp_count[4:0];
            fc.truncated    = dp_ovf;
            fc.last         = (k + 1 == dp_count);
            fresh_chars.push_back(fc);
          end
          dp_count = 0;
          dp_ovf   = 1'b0;
          dp_phase = HUNT;
        end
      end
      default: dp_phase = HUNT;
    endcase
  endfunction

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_char_t want;
    stim_row_t   row;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_chars.size() == 0) begin
          $error("result beat with nothing pending: value_char %0h", out_ch.value_char);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          cmp_field("can_id", want.can_id, out_ch.can_id);
          cmp_field("status_char", want.status_char, out_ch.status_char);
          cmp_field("value_char", want.value_char, out_ch.value_char);
          cmp_field("char_index", want.char_index, out_ch.char_index);
          cmp_field("value_length", want.value_length, out_ch.value_length);
          cmp_field("truncated", want.truncated, out_ch.truncated);
          cmp_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        row = offered_rows.pop_front();
        fresh_chars.delete();
        deframe_byte(in_ch.in_byte);
        // A row with a hand-written expectation overrides the predicted one.
        if (row.typed) begin
          fresh_chars.delete();
          fresh_chars.push_back(row.want);
        end
        foreach (fresh_chars[i]) pending_chars.push_back(fresh_chars[i]);
      end
    end
  end

  // Receiver: switches between stall patterns, plus one long hold-off.
  initial begin
    int tick;
    int mode;
    int hold_left;
    tick      = 0;
    mode      = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (tick % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic stim_row_t plain(input logic [7:0] b);
    stim_row_t r;
    r           = '0;
    r.data_byte = b;
    return r;
  endfunction

  // Closing byte of a one-character frame, with its single result spelled out.
  function automatic stim_row_t closing(input logic [7:0] b, input logic [7:0] id,
                                        input logic [7:0] st, input logic [7:0] ch);
    stim_row_t r;
    r.data_byte = b;
    r.typed     = 1'b1;
    r.want      = '{id, st, ch, 4'd0, 5'd1, 1'b0, 1'b1};
    return r;
  endfunction

  int burst_left;

  task automatic offer(input stim_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    offered_rows.push_back(r);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= r.data_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_chars.size() != 0 || offered_rows.size() != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t  directed [$];
    logic [7:0] fb [$];
    logic [7:0] id;
    logic [7:0] st;
    logic [7:0] wrong;
    int         frame_bytes;
    int         pick;
    int         run_len;
    int         k;
    int         p;
    bit         paused;

    hold_req   = 1'b0;
    burst_left = 0;
    dp_phase   = HUNT;
    dp_id      = '0;
    dp_status  = '0;
    dp_count   = 0;
    dp_ovf     = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      // Lowest ID and status, one digit, closed by 'e'.
      plain(CH_BANG), plain(8'h00), plain(CH_S), plain(CH_0), plain(CH_D), plain(CH_9),
      closing(CH_E, 8'h00, CH_0, CH_9),
      // Highest ID and status; a closing '!' must not open a new frame.
      plain(CH_BANG), plain(8'hff), plain(CH_S), plain(CH_5), plain(CH_D), plain(CH_DOT),
      closing(CH_BANG, 8'hff, CH_5, CH_DOT),
      // Empty value run: no result.
      plain(CH_BANG), plain(8'h41), plain(CH_S), plain(CH_1), plain(CH_D), plain(CH_E),
      // '!' taken as the ID, then a wrong separator drops the frame.
      plain(CH_BANG), plain(CH_BANG), plain(8'h78)
    };
    foreach (directed[i]) offer(directed[i]);
    drain();

    frame_bytes = 0;
    paused      = 1'b0;
    while (frame_bytes < 435) begin
      if (frame_bytes >= 120) hold_req = 1'b1;
      if (frame_bytes >= 300 && !paused) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        // Noise between frames; mostly ignored by the parser.
        repeat ($urandom_range(1, 3)) offer(plain(8'($urandom_range(0, 255))));
      end else begin
        id = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: st = CH_0;
          1: st = CH_1;
          2: st = CH_4;
          default: st = CH_5;
        endcase
        fb = '{CH_BANG, id, CH_S, st, CH_D};
        if (pick >= 75) begin
          // Broken head: a wrong byte at one of the fixed positions.
          p = $urandom_range(2, 4);
          do wrong = 8'($urandom_range(0, 255));
          while ((p == 2 && wrong == CH_S) || (p == 4 && wrong == CH_D) ||
                 (p == 3 && (wrong == CH_0 || wrong == CH_1 || wrong == CH_4 ||
                             wrong == CH_5)));
          fb[p] = wrong;
          while (fb.size() > p + 1) void'(fb.pop_back());
        end else begin
          k = $urandom_range(0, 99);
          if (k < 8)       run_len = 0;
          else if (k < 20) run_len = $urandom_range(15, 22);
          else             run_len = $urandom_range(1, 6);
          repeat (run_len) begin
            k = $urandom_range(0, 10);
            fb.push_back((k == 10) ? CH_DOT : CH_0 + 8'(k));
          end
          case ($urandom_range(0, 3))
            0: fb.push_back(CH_E);
            1: fb.push_back(CH_BANG);
            default: begin
              do wrong = 8'($urandom_range(0, 255));
              while ((wrong >= CH_0 && wrong <= CH_9) || wrong == CH_DOT);
              fb.push_back(wrong);
            end
          endcase
        end
        foreach (fb[i]) offer(plain(fb[i]));
        frame_bytes += fb.size();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
